// ===== rtl/rtsb_pkg.sv =====
// Package for the RGB565 threshold/scale bit-plane block.
// Holds plane geometry, field widths, operation codes and the structs shared
// between the mapping pipeline, the plane memory unit and the top level.
`timescale 1ns / 1ps

package rtsb_pkg;

    // Plane geometry.
    localparam int PLANE_W     = 232;
    localparam int PLANE_H     = 300;
    localparam int ROW_BYTES   = (PLANE_W + 7) / 8;
    localparam int PLANE_BYTES = ROW_BYTES * PLANE_H;
    localparam int ADDR_W      = $clog2(PLANE_BYTES);
    localparam int X_W         = $clog2(PLANE_W);
    localparam int Y_W         = $clog2(PLANE_H);

    // Field widths fixed by the interface.
    localparam int FUNC_W    = 2;
    localparam int PIXEL_W   = 16;
    localparam int COORD_IN_W = 16;
    localparam int BYTE_IDX_W = 14;
    localparam int SCALE_W   = 24;
    localparam int OFFX_W    = 9;
    localparam int OFFY_W    = 10;
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // Scaling arithmetic: 16 x 24 bit product, Q16 rounding, signed result.
    localparam int PROD_W  = COORD_IN_W + SCALE_W;
    localparam int SCALED_W = PROD_W - 16;
    localparam int COORD_W = SCALED_W + 2;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32'h0000_8000);

    // Luma weights; the weighted sum is compared against threshold * 1000.
    localparam int LUMA_SUM_W = 18;
    localparam logic [LUMA_SUM_W-1:0] LUMA_R   = LUMA_SUM_W'(299);
    localparam logic [LUMA_SUM_W-1:0] LUMA_G   = LUMA_SUM_W'(587);
    localparam logic [LUMA_SUM_W-1:0] LUMA_B   = LUMA_SUM_W'(114);
    localparam logic [LUMA_SUM_W-1:0] LUMA_DIV = LUMA_SUM_W'(1000);

    // Operation codes carried in tuser.
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_WRITE = 2'd0;
    localparam t_func FUNC_READ  = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCALE     = 2'd0;
    localparam t_cfg_idx CFG_OFFSET_X  = 2'd1;
    localparam t_cfg_idx CFG_OFFSET_Y  = 2'd2;
    localparam t_cfg_idx CFG_THRESHOLD = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_RESET     = 24'd65536;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 8'd140;

    typedef struct packed {
        logic [SCALE_W-1:0] scale_q16;
        logic [OFFX_W-1:0]  offset_x;
        logic [OFFY_W-1:0]  offset_y;
        logic [THR_W-1:0]   black_threshold;
    } t_cfg;

    typedef struct packed {
        t_func                  func;
        logic [PIXEL_W-1:0]     pixel;
        logic [COORD_IN_W-1:0]  src_x;
        logic [COORD_IN_W-1:0]  src_y;
        logic [BYTE_IDX_W-1:0]  byte_index;
    } t_item;

    // One plane access: new byte = (old & keep) | setb when we is set.
    typedef struct packed {
        logic              we;
        logic              ret;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        keep;
        logic [7:0]        setb;
        logic              in_window;
        logic              is_black;
    } t_op;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       in_window;
        logic       is_black;
    } t_res;

endpackage

// ===== rtl/rtsb_map.sv =====
// Mapping pipeline: luma threshold, coordinate scaling, clipping and plane
// address generation, in three registered stages. Depends on rtsb_pkg.
`timescale 1ns / 1ps

module rtsb_map (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtsb_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  rtsb_pkg::t_item i_item,
    output logic            o_op_valid,
    input  logic            i_op_ready,
    output rtsb_pkg::t_op   o_op
);
    import rtsb_pkg::*;

    // Stage 1: products.
    logic                  r1_v;
    t_func                 r1_func;
    logic [BYTE_IDX_W-1:0] r1_bi;
    logic [PROD_W-1:0]     r1_px, r1_py;
    logic [LUMA_SUM_W-1:0] r1_luma;

    // Stage 2: scaled and clipped coordinates.
    logic                  r2_v;
    t_func                 r2_func;
    logic [BYTE_IDX_W-1:0] r2_bi;
    logic                  r2_bi_ok;
    logic                  r2_win;
    logic                  r2_blk;
    logic [X_W-1:0]        r2_x;
    logic [Y_W-1:0]        r2_y;

    // Stage 3: plane operation.
    logic r3_v;
    t_op  r3_op;

    logic rdy1, rdy2, rdy3;

    logic [7:0]            n1_r, n1_g, n1_b;
    logic [LUMA_SUM_W-1:0] n1_luma;
    logic [PROD_W-1:0]     n2_rx, n2_ry;
    logic signed [COORD_W-1:0] n2_dx, n2_dy;
    logic [LUMA_SUM_W-1:0] n2_thr;
    logic [7:0]            n3_mask;
    logic [ADDR_W-1:0]     n3_pix_addr;
    t_op                   n3_op;

    assign rdy3    = !r3_v || i_op_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        n1_r = {i_item.pixel[15:11], 3'b000};
        n1_g = {i_item.pixel[10:5], 2'b00};
        n1_b = {i_item.pixel[4:0], 3'b000};
        n1_luma = LUMA_SUM_W'(n1_r) * LUMA_R + LUMA_SUM_W'(n1_g) * LUMA_G
                + LUMA_SUM_W'(n1_b) * LUMA_B;
    end

    always_comb begin
        n2_rx  = r1_px + ROUND_HALF;
        n2_ry  = r1_py + ROUND_HALF;
        n2_dx  = $signed({2'b00, n2_rx[PROD_W-1:16]})
               + $signed({{(COORD_W-OFFX_W){i_cfg.offset_x[OFFX_W-1]}}, i_cfg.offset_x});
        n2_dy  = $signed({2'b00, n2_ry[PROD_W-1:16]})
               + $signed({{(COORD_W-OFFY_W){i_cfg.offset_y[OFFY_W-1]}}, i_cfg.offset_y});
        n2_thr = LUMA_SUM_W'(i_cfg.black_threshold) * LUMA_DIV;
    end

    always_comb begin
        n3_mask     = 8'h80 >> r2_x[2:0];
        n3_pix_addr = ADDR_W'(r2_y) * ADDR_W'(ROW_BYTES) + ADDR_W'(r2_x >> 3);
        n3_op       = '0;
        unique case (r2_func)
            FUNC_WRITE: begin
                n3_op.we        = r2_win;
                n3_op.addr      = r2_win ? n3_pix_addr : '0;
                n3_op.keep      = ~n3_mask;
                n3_op.setb      = r2_blk ? n3_mask : 8'h00;
                n3_op.in_window = r2_win;
                n3_op.is_black  = r2_blk;
            end
            FUNC_READ: begin
                n3_op.ret  = r2_bi_ok;
                n3_op.addr = r2_bi_ok ? ADDR_W'(r2_bi) : '0;
            end
            FUNC_CLEAR: begin
                n3_op.we   = r2_bi_ok;
                n3_op.addr = r2_bi_ok ? ADDR_W'(r2_bi) : '0;
            end
            default: begin
                n3_op = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_func <= i_item.func;
            r1_bi   <= i_item.byte_index;
            r1_px   <= PROD_W'(i_item.src_x) * PROD_W'(i_cfg.scale_q16);
            r1_py   <= PROD_W'(i_item.src_y) * PROD_W'(i_cfg.scale_q16);
            r1_luma <= n1_luma;
        end
        if (rdy2) begin
            r2_func  <= r1_func;
            r2_bi    <= r1_bi;
            r2_bi_ok <= (32'(r1_bi) < 32'(PLANE_BYTES));
            r2_win   <= !n2_dx[COORD_W-1] && !n2_dy[COORD_W-1]
                        && (n2_dx < COORD_W'(PLANE_W)) && (n2_dy < COORD_W'(PLANE_H));
            r2_blk   <= (r1_luma < n2_thr);
            r2_x     <= n2_dx[X_W-1:0];
            r2_y     <= n2_dy[Y_W-1:0];
        end
        if (rdy3) begin
            r3_op <= n3_op;
        end
    end

    assign o_op_valid = r3_v;
    assign o_op       = r3_op;

endmodule

// ===== rtl/rtsb_plane.sv =====
// Bit-plane memory unit: synchronous one-port-write, one-port-read memory with
// read-modify-write, forwarding, clearing pass and output register. Uses rtsb_pkg.
`timescale 1ns / 1ps

module rtsb_plane (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    output logic           o_op_ready,
    input  rtsb_pkg::t_op  i_op,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output rtsb_pkg::t_res o_res,
    output logic           o_clearing
);
    import rtsb_pkg::*;

    logic [7:0] r_mem [PLANE_BYTES];

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic       r_b_v;
    t_op        r_b_op;
    logic [7:0] r_rd;
    logic       r_fwd_v;
    logic [7:0] r_fwd_data;

    logic r_c_v;
    t_res r_c_res;

    logic              rdy_b, rdy_c, a_move, b_move;
    logic [7:0]        cur, n_byte;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;
    t_res              n_res;

    assign rdy_c      = !r_c_v || i_res_ready;
    assign rdy_b      = !r_b_v || rdy_c;
    assign b_move     = r_b_v && rdy_c;
    assign o_op_ready = rdy_b && !r_clr_busy;
    assign a_move     = i_op_valid && o_op_ready;

    // The byte written by the stage ahead is not yet visible to a read issued
    // in the same cycle, so it is forwarded instead.
    assign cur    = r_fwd_v ? r_fwd_data : r_rd;
    assign n_byte = (cur & r_b_op.keep) | r_b_op.setb;

    always_comb begin
        we = r_clr_busy || (b_move && r_b_op.we);
        wa = r_clr_busy ? r_clr_addr : r_b_op.addr;
        wd = r_clr_busy ? 8'h00 : n_byte;
        n_res.read_byte = r_b_op.ret ? cur : 8'h00;
        n_res.in_window = r_b_op.in_window;
        n_res.is_black  = r_b_op.is_black;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (a_move) r_rd <= r_mem[i_op.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(PLANE_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (rdy_b) r_b_v <= a_move;
            if (rdy_c) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_op     <= i_op;
            r_fwd_v    <= b_move && r_b_op.we && (r_b_op.addr == i_op.addr);
            r_fwd_data <= n_byte;
        end
        if (b_move) begin
            r_c_res <= n_res;
        end
    end

    assign o_res_valid = r_c_v;
    assign o_res       = r_c_res;
    assign o_clearing  = r_clr_busy;

    // Nothing from the pipeline may reach the memory while it is being cleared.
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_b_v && !r_c_v && !a_move))
        else $error("plane access during clearing pass");

    // Once finished, the clearing pass never restarts without reset.
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy |=> !r_clr_busy)
        else $error("clearing pass restarted");

    // An accepted access always occupies the read stage in the next cycle.
    a_issue_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_move |=> r_b_v)
        else $error("accepted access lost");

    // Only a read returns plane data, and a read never reports pixel flags.
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_v && (r_c_res.read_byte != 8'h00)) |->
            (!r_c_res.in_window && !r_c_res.is_black))
        else $error("read result mixed with pixel flags");

endmodule

// ===== rtl/rgb565_threshold_scale_bitplane.sv =====
// Top level of the RGB565 luma-threshold nearest-neighbor scaler into a
// one-bit-per-pixel plane. Instantiates rtsb_map and rtsb_plane; uses rtsb_pkg.
`timescale 1ns / 1ps

// How to use this block:
// The slave stream (i_s_*) takes one transaction per operation: tuser holds
// the operation (write pixel, read plane byte, clear plane byte) and tdata
// holds the pixel, the source coordinates and the byte address. Every
// operation returns exactly one transaction on the master stream (o_m_*),
// carrying the read byte and the in-window and black flags, in order.
// Configuration registers (scale, offsets, threshold) are written through
// the i_cfg_* channel, which is always ready; write them only while no
// operation is in flight.
// Pipeline: an operation passes three mapping stages, the memory read and
// the modify/write-back stage, each registered. Throughput is one operation
// per cycle while the receiver is ready and no clearing pass runs; a
// write followed at once by an access to the same byte is served by
// forwarding the freshly modified byte, so there is no interlock bubble.
// Reset: after i_rst_n is released the plane memory is swept to zero, one
// byte per cycle over all 8700 bytes; o_s_tready stays low during that pass.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep accepting until every stage is full.
module rgb565_threshold_scale_bitplane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rtsb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtsb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Operation stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata from bit 0: pixel[15:0], src_x[31:16], src_y[47:32],
    // byte_index[61:48], zero pad [63:62].
    input  logic [63:0]                        i_s_tdata,
    // tuser: func[1:0].
    input  logic [rtsb_pkg::FUNC_W-1:0]        i_s_tuser,
    // Result stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata from bit 0: read_byte[7:0], in_window[8], is_black[9],
    // zero pad [15:10].
    output logic [15:0]                        o_m_tdata
);
    import rtsb_pkg::*;

    t_cfg  r_cfg;
    t_item item;
    t_op   op;
    t_res  res;
    logic  op_valid, op_ready;
    logic  map_ready;
    logic  clearing;

    // Configuration registers. The channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_q16       <= SCALE_RESET;
            r_cfg.offset_x        <= '0;
            r_cfg.offset_y        <= '0;
            r_cfg.black_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCALE:     r_cfg.scale_q16       <= i_cfg_data[SCALE_W-1:0];
                CFG_OFFSET_X:  r_cfg.offset_x        <= i_cfg_data[OFFX_W-1:0];
                CFG_OFFSET_Y:  r_cfg.offset_y        <= i_cfg_data[OFFY_W-1:0];
                CFG_THRESHOLD: r_cfg.black_threshold <= i_cfg_data[THR_W-1:0];
                default:       r_cfg.scale_q16       <= r_cfg.scale_q16;
            endcase
        end
    end

    // Unpack the incoming transaction.
    always_comb begin
        item.func       = i_s_tuser;
        item.pixel      = i_s_tdata[15:0];
        item.src_x      = i_s_tdata[31:16];
        item.src_y      = i_s_tdata[47:32];
        item.byte_index = i_s_tdata[61:48];
    end

    // No operation enters while the plane is being cleared after reset.
    assign o_s_tready = map_ready && !clearing;

    rtsb_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_tvalid && !clearing),
        .o_ready    (map_ready),
        .i_item     (item),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    rtsb_plane u_plane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res),
        .o_clearing  (clearing)
    );

    assign o_m_tdata = {6'b000000, res.is_black, res.in_window, res.read_byte};

endmodule

// ===== verif/rgb565_threshold_scale_bitplane_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for rgb565_threshold_scale_bitplane: keeps its own copy of the bit
// plane and of the registers, predicts one result per operation, checks in order.
// Depends on rtsb_pkg for widths, operation codes and register indexes.

module rgb565_threshold_scale_bitplane_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [rtsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtsb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [63:0]                     i_s_tdata,
    input  logic [rtsb_pkg::FUNC_W-1:0]     i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [15:0]                     i_m_tdata,
    output int                              o_mismatch_count,
    output int                              o_results_due
);
    import rtsb_pkg::*;

    logic [7:0]          plane_copy [PLANE_BYTES];
    logic [SCALE_W-1:0]  scale_copy;
    logic signed [8:0]   offset_x_copy;
    logic signed [9:0]   offset_y_copy;
    logic [THR_W-1:0]    threshold_copy;

    t_res results_due [$];
    t_res got;
    t_res want;
    int   mismatch_count = 0;

    // Applies one operation to the plane copy and returns the result it owes.
    function automatic t_res apply_plane_op(t_func op, logic [15:0] pix,
                                            logic [15:0] sx, logic [15:0] sy,
                                            logic [13:0] bi);
        t_res        r;
        int unsigned luma;
        longint      col;
        longint      row;
        int          addr;
        logic [7:0]  mask;
        r = '0;
        case (op)
            FUNC_WRITE: begin
                luma = (int'({pix[15:11], 3'b000}) * 299 + int'({pix[10:5], 2'b00}) * 587
                        + int'({pix[4:0], 3'b000}) * 114) / 1000;
                r.is_black = (luma < int'(threshold_copy));
                col = longint'(offset_x_copy)
                    + longint'((64'(sx) * 64'(scale_copy) + 64'h8000) >> 16);
                row = longint'(offset_y_copy)
                    + longint'((64'(sy) * 64'(scale_copy) + 64'h8000) >> 16);
                if (col >= 0 && row >= 0 && col < PLANE_W && row < PLANE_H) begin
                    addr = int'(row) * ROW_BYTES + int'(col / 8);
                    mask = 8'h80 >> (col % 8);
                    plane_copy[addr] = r.is_black ? (plane_copy[addr] | mask)
                                                  : (plane_copy[addr] & ~mask);
                    r.in_window = 1'b1;
                end
            end
            FUNC_READ: begin
                if (int'(bi) < PLANE_BYTES) r.read_byte = plane_copy[bi];
            end
            FUNC_CLEAR: begin
                if (int'(bi) < PLANE_BYTES) plane_copy[bi] = 8'h00;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < PLANE_BYTES; a++) plane_copy[a] = 8'h00;
            scale_copy     = SCALE_RESET;
            offset_x_copy  = '0;
            offset_y_copy  = '0;
            threshold_copy = THRESHOLD_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCALE:     scale_copy     = i_cfg_data[SCALE_W-1:0];
                    CFG_OFFSET_X:  offset_x_copy  = i_cfg_data[OFFX_W-1:0];
                    CFG_OFFSET_Y:  offset_y_copy  = i_cfg_data[OFFY_W-1:0];
                    CFG_THRESHOLD: threshold_copy = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.read_byte = i_m_tdata[7:0];
                got.in_window = i_m_tdata[8];
                got.is_black  = i_m_tdata[9];
                if (results_due.size() == 0) begin
                    $error("result transaction with no operation outstanding: tdata %h",
                           i_m_tdata);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.read_byte !== want.read_byte) begin
                        $error("read_byte: expected %h, actual %h",
                               want.read_byte, got.read_byte);
                        mismatch_count++;
                    end
                    if (got.in_window !== want.in_window) begin
                        $error("in_window: expected %b, actual %b",
                               want.in_window, got.in_window);
                        mismatch_count++;
                    end
                    if (got.is_black !== want.is_black) begin
                        $error("is_black: expected %b, actual %b",
                               want.is_black, got.is_black);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                results_due.push_back(apply_plane_op(t_func'(i_s_tuser), i_s_tdata[15:0],
                                                     i_s_tdata[31:16], i_s_tdata[47:32],
                                                     i_s_tdata[61:48]));
            end
        end
        o_results_due    = results_due.size();
        o_mismatch_count = mismatch_count;
    end

endmodule

// ===== verif/rgb565_threshold_scale_bitplane_test.sv =====
`timescale 1ns / 1ps
// Testbench top for rgb565_threshold_scale_bitplane: drives operations and
// register writes, and gives the verdict from the scoreboard's mismatch count.
// Depends on rtsb_pkg, the block and rgb565_threshold_scale_bitplane_checker.

module rgb565_threshold_scale_bitplane_test;
    import rtsb_pkg::*;

    // Function code 3 is not assigned to any operation; the block must answer
    // it with an all-zero result and leave the plane alone.
    localparam t_func FUNC_UNUSED = 2'd3;

    // The random part runs through several register settings, each one a
    // phase of operations aimed at a band of plane rows.
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int RANDOM_ITEMS    = PHASES * ITEMS_PER_PHASE;
    localparam int HOT_ROWS        = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [63:0]           s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_ready;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [15:0]           m_tdata;
    int                    mismatch_count;
    int                    results_due;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int src_idle_pct = 20;
    int dst_idle_pct = 73;

    // Copies of the register settings, used only to aim source coordinates at
    // interesting parts of the plane; the scoreboard keeps its own.
    int cur_scale = 65536;
    int cur_offx  = 0;
    int cur_offy  = 0;

    always #5 clk = ~clk;

    rgb565_threshold_scale_bitplane dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    rgb565_threshold_scale_bitplane_checker result_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    // The receiver decides afresh at every falling edge whether it stalls.
    always @(negedge clk) begin
        m_tready <= rst_n && ($urandom_range(99) >= dst_idle_pct);
    end

    // Presents one operation, after a random number of idle cycles, and
    // returns at the falling edge after the transaction. tvalid is left high
    // so that the next call can either present again or idle.
    task automatic issue_op(t_func op, logic [15:0] pix, logic [15:0] sx,
                            logic [15:0] sy, logic [13:0] bi);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, bi, sy, sx, pix};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // One register write transaction. The caller lowers cfg_valid after the
    // last write of a group.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Picks a source coordinate that the current scale maps near the wanted
    // plane coordinate. With a zero scale every source lands on the offset,
    // so any value will do.
    function automatic logic [15:0] src_toward(int target, int off);
        longint num;
        if (cur_scale == 0) return 16'($urandom);
        num = (longint'(target - off) * 65536) / cur_scale;
        if (num < 0) return 16'($urandom_range(2));
        if (num > 65535) return 16'hFFFF - 16'($urandom_range(2));
        return 16'(num + $urandom_range(1));
    endfunction

    // One random operation. Most writes aim at a band of rows and most reads
    // and clears hit that same band, so read-back sees real plane contents;
    // the rest is noise over the whole field ranges.
    task automatic issue_random_op(int hot_row);
        int         pick;
        int         tx;
        int         ty;
        logic [13:0] hot_byte;
        pick     = $urandom_range(99);
        tx       = $urandom_range(PLANE_W + 3) - 2;
        ty       = hot_row + $urandom_range(HOT_ROWS - 1);
        hot_byte = 14'(ty * ROW_BYTES + $urandom_range(ROW_BYTES - 1));
        if ($urandom_range(9) == 0) ty = $urandom_range(PLANE_H + 3) - 2;
        if (pick < 50) begin
            issue_op(FUNC_WRITE, 16'($urandom), src_toward(tx, cur_offx),
                     src_toward(ty, cur_offy), 14'($urandom));
        end else if (pick < 58) begin
            issue_op(FUNC_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                     14'($urandom));
        end else if (pick < 85) begin
            issue_op(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom), hot_byte);
        end else if (pick < 90) begin
            issue_op(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                     14'($urandom));
        end else if (pick < 96) begin
            issue_op(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                     ($urandom_range(1) == 0) ? hot_byte : 14'($urandom));
        end else begin
            issue_op(FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                     14'($urandom));
        end
    endtask

    initial begin
        int hot_row;
        int issued;
        int new_thr;
        issued = 0;

        // Synchronous reset; afterwards the block sweeps its plane to zero
        // with tready low, which issue_op simply waits out.
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: scale 1.0, no offsets and a
        // threshold of 140. Pure white stays white, the pure primaries fall
        // on both sides of the threshold.
        issue_op(FUNC_WRITE, 16'hFFFF, 16'd0, 16'd0, 14'd0);
        issue_op(FUNC_WRITE, 16'h0000, 16'd0, 16'd0, 14'h3FFF);
        issue_op(FUNC_WRITE, 16'hF800, 16'd1, 16'd0, 14'd0);
        issue_op(FUNC_WRITE, 16'h07E0, 16'd2, 16'd0, 14'd0);
        issue_op(FUNC_WRITE, 16'h001F, 16'd3, 16'd0, 14'd0);
        // Last pixel of the plane, then one column past the right edge, one row
        // past the bottom edge, and the farthest source coordinates.
        issue_op(FUNC_WRITE, 16'h0000, 16'(PLANE_W - 1), 16'(PLANE_H - 1), 14'd0);
        issue_op(FUNC_WRITE, 16'h0000, 16'(PLANE_W), 16'd5, 14'd0);
        issue_op(FUNC_WRITE, 16'h0000, 16'd5, 16'(PLANE_H), 14'd0);
        issue_op(FUNC_WRITE, 16'h0000, 16'hFFFF, 16'hFFFF, 14'd0);
        // Reads of the first and last byte, then addresses past the plane.
        issue_op(FUNC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'd0);
        issue_op(FUNC_READ, 16'h0000, 16'h0000, 16'h0000, 14'(PLANE_BYTES - 1));
        issue_op(FUNC_READ, 16'h0000, 16'h0000, 16'h0000, 14'(PLANE_BYTES));
        issue_op(FUNC_READ, 16'h0000, 16'h0000, 16'h0000, 14'h3FFF);
        // Consecutive accesses to one byte can exercise the write forwarding.
        issue_op(FUNC_WRITE, 16'h0000, 16'd7, 16'd0, 14'd0);
        issue_op(FUNC_READ, 16'h0000, 16'd0, 16'd0, 14'd0);
        issue_op(FUNC_WRITE, 16'hFFFF, 16'd7, 16'd0, 14'd0);
        issue_op(FUNC_READ, 16'h0000, 16'd0, 16'd0, 14'd0);
        issue_op(FUNC_CLEAR, 16'h0000, 16'd0, 16'd0, 14'd0);
        issue_op(FUNC_READ, 16'h0000, 16'd0, 16'd0, 14'd0);
        issue_op(FUNC_CLEAR, 16'h0000, 16'd0, 16'd0, 14'(PLANE_BYTES - 1));
        issue_op(FUNC_READ, 16'h0000, 16'd0, 16'd0, 14'(PLANE_BYTES - 1));
        issue_op(FUNC_CLEAR, 16'h0000, 16'd0, 16'd0, 14'h3FFF);
        issue_op(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            // Registers change only once every result of the last phase has
            // come back; each operation owes exactly one result, so nothing
            // can still be in flight at that point.
            wait (results_due == 0);
            @(negedge clk);
            case (p)
                0: begin
                    cur_scale = 65536; cur_offx = 0; cur_offy = 0; new_thr = 140;
                end
                1: begin
                    cur_scale = 24'hFFFFFF; cur_offx = -256; cur_offy = -512;
                    new_thr = 128;
                end
                2: begin
                    // Zero scale: every pixel lands on the last plane pixel.
                    cur_scale = 0; cur_offx = PLANE_W - 1; cur_offy = PLANE_H - 1;
                    new_thr = 255;
                end
                3: begin
                    cur_scale = 32768; cur_offx = -20; cur_offy = 10; new_thr = 200;
                end
                4: begin
                    cur_scale = 163840; cur_offx = 7; cur_offy = -3; new_thr = 1;
                end
                5: begin
                    // Largest offsets push everything off the plane.
                    cur_scale = 65536; cur_offx = 255; cur_offy = 511; new_thr = 0;
                end
                6: begin
                    cur_scale = $urandom_range(16384, 131072);
                    cur_offx  = $urandom_range(80) - 40;
                    cur_offy  = $urandom_range(80) - 40;
                    new_thr   = $urandom_range(255);
                end
                default: begin
                    cur_scale = 65536; cur_offx = -5; cur_offy = -7; new_thr = 139;
                end
            endcase
            write_reg(CFG_SCALE, CFG_DATA_W'(cur_scale));
            write_reg(CFG_OFFSET_X, {15'b0, 9'(cur_offx)});
            write_reg(CFG_OFFSET_Y, {14'b0, 10'(cur_offy)});
            write_reg(CFG_THRESHOLD, {16'b0, 8'(new_thr)});
            cfg_valid <= 1'b0;

            hot_row = $urandom_range(PLANE_H - HOT_ROWS);
            repeat (ITEMS_PER_PHASE) begin
                // Idle pattern over the random part: sender light and
                // receiver heavy, then the reverse, then no idling at all.
                if (issued < RANDOM_ITEMS / 3) begin
                    src_idle_pct = 20;
                    dst_idle_pct = 73;
                end else if (issued < 2 * RANDOM_ITEMS / 3) begin
                    src_idle_pct = 73;
                    dst_idle_pct = 20;
                end else begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
                issue_random_op(hot_row);
                issued++;
            end
            s_tvalid <= 1'b0;
        end

        // Drain the pipeline, then give any stray result time to appear.
        wait (results_due == 0);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: well beyond the plane sweep plus every operation at its
    // slowest idle and stall pattern.
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
